// ===== sv/solve_linear_system_3x3_assert.svh =====
// Assertion macros for the 3x3 linear system solver.
// Used by solve_linear_system_3x3.sv; expects clk and rst_n in scope.
`ifndef SOLVE_LINEAR_SYSTEM_3X3_ASSERT_SVH
`define SOLVE_LINEAR_SYSTEM_3X3_ASSERT_SVH

// same-cycle implication
`define SLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sls_pkg.sv =====
// Shared widths and latencies for the 3x3 linear system solver.
// No dependencies; used by sls_div.sv and solve_linear_system_3x3.sv.
package sls_pkg;
  localparam int DW        = 32;   // Q16.16 field width
  localparam int FRAC      = 16;
  localparam int PW        = 64;   // 32x32 product
  localparam int CW        = 65;   // cross product component
  localparam int TW        = 97;   // triple product, Q48.48
  localparam int DIV_STEPS = 32;   // quotient bits developed, one per stage
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int PRE_LAT   = 7;    // input reg through magnitude stage
  localparam int LAT       = PRE_LAT + DIV_LAT + 1;
endpackage

// ===== sv/sls_div.sv =====
// Pipelined restoring divider lane: round(a*2^16/d) for magnitudes a, d.
// Depends on sls_pkg. One quotient bit per stage; flags quotients >= 2^32.
module sls_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [sls_pkg::TW-1:0]  a_i,
  input  logic [sls_pkg::TW-1:0]  d_i,
  input  logic                    neg_i,
  output logic [sls_pkg::DW:0]    q_o,
  output logic                    presat_o,
  output logic                    neg_o
);
  localparam int S = sls_pkg::DIV_STEPS;
  localparam int TW = sls_pkg::TW;
  localparam int DW = sls_pkg::DW;
  localparam int FR = sls_pkg::FRAC;

  logic [TW-1:0] rem_r [0:S];
  logic [DW-1:0] xl_r  [0:S];
  logic [DW-1:0] q_r   [0:S];
  logic [TW-1:0] d_r   [0:S];
  logic          neg_r [0:S];
  logic          ps_r  [0:S];
  logic [DW:0]   q_out_r;
  logic          ps_out_r;
  logic          neg_out_r;
  logic          presat;

  // a*2^16 >= d*2^32 means the quotient cannot fit in 32 bits
  assign presat = {{FR{1'b0}}, a_i} >= {d_i, {FR{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {{FR{1'b0}}, a_i[TW-1:FR]};
      xl_r[0]  <= {a_i[FR-1:0], {(DW-FR){1'b0}}};
      q_r[0]   <= '0;
      d_r[0]   <= d_i;
      neg_r[0] <= neg_i;
      ps_r[0]  <= presat;
    end
  end

  for (genvar k = 1; k <= S; k++) begin : g_step
    logic [TW:0]   t;
    logic          ge;
    logic [TW-1:0] rn;
    always_comb begin
      t  = {rem_r[k-1], xl_r[k-1][DW-1]};
      ge = t >= {1'b0, d_r[k-1]};
      rn = ge ? TW'(t - {1'b0, d_r[k-1]}) : t[TW-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rn;
        xl_r[k]  <= {xl_r[k-1][DW-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][DW-2:0], ge};
        d_r[k]   <= d_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ps_r[k]  <= ps_r[k-1];
      end
    end
  end

  // round to nearest, ties away from zero (on magnitude)
  logic inc;
  assign inc = {rem_r[S], 1'b0} >= {1'b0, d_r[S]};

  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r   <= {1'b0, q_r[S]} + (DW+1)'(inc);
      ps_out_r  <= ps_r[S];
      neg_out_r <= neg_r[S];
    end
  end

  assign q_o      = q_out_r;
  assign presat_o = ps_out_r;
  assign neg_o    = neg_out_r;
endmodule

// ===== sv/solve_linear_system_3x3.sv =====
// Top level of the 3x3 linear system solver (Cramer's rule, Q16.16).
// Depends on sls_pkg, sls_div and solve_linear_system_3x3_assert.svh.
//
// Usage:
//   Input channel in_valid/in_ready carries the nine matrix entries and the
//   right-hand side; output channel out_valid/out_ready returns the solution
//   with singular and saturated flags. Both are valid/ready handshakes.
//   Latency: 42 register stages: the input register plus 6 stages of cross
//   products, partial products, sums and magnitudes, then the divider
//   lanes (setup, one quotient bit per stage, rounding) and one output
//   register stage.
//   Throughput: one transaction per cycle while the output is not stalled;
//   the 32-stage restoring divider lanes, one per solution entry, set the depth.
//   Stall: when out_valid is high and out_ready is low the whole pipeline
//   holds, in_ready drops, and no transaction is lost or repeated.
//   Reset: synchronous active-low rst_n clears all valid bits; the pipeline
//   comes up empty and in_ready is high the cycle after reset.
//   Singular matrix: solution zero, singular high, saturated low.
`include "solve_linear_system_3x3_assert.svh"
module solve_linear_system_3x3 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_a11,
  input  logic signed [31:0] in_a12,
  input  logic signed [31:0] in_a13,
  input  logic signed [31:0] in_a21,
  input  logic signed [31:0] in_a22,
  input  logic signed [31:0] in_a23,
  input  logic signed [31:0] in_a31,
  input  logic signed [31:0] in_a32,
  input  logic signed [31:0] in_a33,
  input  logic signed [31:0] in_rhs_x,
  input  logic signed [31:0] in_rhs_y,
  input  logic signed [31:0] in_rhs_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_sol_x,
  output logic signed [31:0] out_sol_y,
  output logic signed [31:0] out_sol_z,
  output logic        out_singular,
  output logic        out_saturated
);
  localparam int DW  = sls_pkg::DW;
  localparam int PW  = sls_pkg::PW;
  localparam int CW  = sls_pkg::CW;
  localparam int TW  = sls_pkg::TW;
  localparam int LAT = sls_pkg::LAT;
  localparam int DL  = sls_pkg::DIV_LAT;

  logic en;
  logic vld_r [0:LAT-1];
  logic sing_r [0:DL];

  logic signed [DW-1:0] m_r [3][3];
  logic signed [DW-1:0] b_r [3];
  logic signed [DW-1:0] c1_1r [3], b_1r [3], c1_2r [3], b_2r [3];
  logic signed [PW-1:0] pp_r [3][3][2];
  logic signed [CW-1:0] cr_r [3][3];
  logic signed [CW-1:0] ph_r [4][3], pl_r [4][3];
  logic signed [TW-1:0] term_r [4][3];
  logic signed [TW-1:0] sum_r [4];
  logic [TW-1:0]        mag_r [4];
  logic                 sgn_r [4];

  logic signed [DW-1:0] vv [3][3], ww [3][3], uu [4][3];

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0][0] <= in_a11; m_r[0][1] <= in_a12; m_r[0][2] <= in_a13;
      m_r[1][0] <= in_a21; m_r[1][1] <= in_a22; m_r[1][2] <= in_a23;
      m_r[2][0] <= in_a31; m_r[2][1] <= in_a32; m_r[2][2] <= in_a33;
      b_r[0] <= in_rhs_x; b_r[1] <= in_rhs_y; b_r[2] <= in_rhs_z;
    end
  end

  // cross products: col2 x col3, b x col3, col2 x b
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vv[0][i] = m_r[i][1]; ww[0][i] = m_r[i][2];
      vv[1][i] = b_r[i];    ww[1][i] = m_r[i][2];
      vv[2][i] = m_r[i][1]; ww[2][i] = b_r[i];
    end
  end

  // stage 1: 32x32 products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int x = 0; x < 3; x++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[x][j][0] <= PW'(vv[x][(j+1)%3]) * PW'(ww[x][(j+2)%3]);
          pp_r[x][j][1] <= PW'(vv[x][(j+2)%3]) * PW'(ww[x][(j+1)%3]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        c1_1r[i] <= m_r[i][0];
        b_1r[i]  <= b_r[i];
      end
    end
  end

  // stage 2: cross components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int x = 0; x < 3; x++)
        for (int j = 0; j < 3; j++)
          cr_r[x][j] <= CW'(pp_r[x][j][0]) - CW'(pp_r[x][j][1]);
      for (int i = 0; i < 3; i++) begin
        c1_2r[i] <= c1_1r[i];
        b_2r[i]  <= b_1r[i];
      end
    end
  end

  // triples: det = c1.X0, n1 = b.X0, n2 = c1.X1, n3 = c1.X2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uu[0][i] = c1_2r[i];
      uu[1][i] = b_2r[i];
      uu[2][i] = c1_2r[i];
      uu[3][i] = c1_2r[i];
    end
  end

  // stage 3: u times high (signed 33b) and low (unsigned 32b) halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 4; t++) begin
        for (int j = 0; j < 3; j++) begin
          ph_r[t][j] <= CW'(uu[t][j]) *
                        CW'($signed(cr_r[(t == 0) ? 0 : t-1][j][CW-1:DW]));
          pl_r[t][j] <= CW'(uu[t][j]) *
                        CW'($signed({1'b0, cr_r[(t == 0) ? 0 : t-1][j][DW-1:0]}));
        end
      end
    end
  end

  // stage 4: recombine halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 4; t++)
        for (int j = 0; j < 3; j++)
          term_r[t][j] <= $signed({ph_r[t][j], {DW{1'b0}}}) +
                          $signed({{(TW-CW){pl_r[t][j][CW-1]}}, pl_r[t][j]});
    end
  end

  // stage 5: sum of three terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 4; t++)
        sum_r[t] <= term_r[t][0] + term_r[t][1] + term_r[t][2];
    end
  end

  // stage 6: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 4; t++) begin
        mag_r[t] <= sum_r[t][TW-1] ? TW'(-sum_r[t]) : TW'(sum_r[t]);
        sgn_r[t] <= sum_r[t][TW-1];
      end
      sing_r[0] <= (sum_r[0] == '0);
      for (int i = 1; i <= DL; i++) sing_r[i] <= sing_r[i-1];
    end
  end

  logic [DW:0] q_w [3];
  logic        ps_w [3];
  logic        ng_w [3];

  for (genvar n = 0; n < 3; n++) begin : g_lane
    sls_div u_div (
      .clk      (clk),
      .en       (en),
      .a_i      (mag_r[n+1]),
      .d_i      (mag_r[0]),
      .neg_i    (sgn_r[n+1] ^ sgn_r[0]),
      .q_o      (q_w[n]),
      .presat_o (ps_w[n]),
      .neg_o    (ng_w[n])
    );
  end

  // output stage: clip, apply sign, zero on singular
  logic [DW-1:0] res [3];
  logic          sat_any;
  always_comb begin
    logic [DW:0] lim;
    logic [DW:0] qq;
    logic        s;
    sat_any = 1'b0;
    for (int n = 0; n < 3; n++) begin
      lim = ng_w[n] ? (DW+1)'(33'h080000000) : (DW+1)'(33'h07fffffff);
      s   = ps_w[n] || (q_w[n] > lim);
      qq  = s ? lim : q_w[n];
      res[n] = ng_w[n] ? DW'(-qq) : DW'(qq);
      sat_any = sat_any | s;
    end
    if (sing_r[DL]) begin
      for (int n = 0; n < 3; n++) res[n] = '0;
      sat_any = 1'b0;
    end
  end

  logic signed [DW-1:0] sx_r, sy_r, sz_r;
  logic                 sing_o_r, sat_o_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r     <= res[0];
      sy_r     <= res[1];
      sz_r     <= res[2];
      sing_o_r <= sing_r[DL];
      sat_o_r  <= sat_any;
    end
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_sol_x     = sx_r;
  assign out_sol_y     = sy_r;
  assign out_sol_z     = sz_r;
  assign out_singular  = sing_o_r;
  assign out_saturated = sat_o_r;

  `SLS_ASSERT_IMP(a_sing_zero, out_valid && out_singular,
    out_sol_x == 0 && out_sol_y == 0 && out_sol_z == 0 && !out_saturated,
    "singular result with nonzero solution or saturation")
  `SLS_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_sol_x) && $stable(out_saturated),
    "stalled result changed")
  `SLS_ASSERT_NXT(a_accept_enters, in_valid && in_ready, vld_r[0],
    "accepted transaction did not enter pipeline")
endmodule
